>>> rtl/rhlt_pkg.sv
// Shared types, constants and arithmetic helpers for the rainbow LED tree pattern block.
`default_nettype none

package rhlt_pkg;

  // Payload widths.
  localparam int COLOR_W    = 8;
  localparam int RGB_W      = 3 * COLOR_W;
  localparam int LINE_W     = 4 * RGB_W;
  localparam int POS_W      = 6;
  localparam int SEL_W      = 3;
  localparam int FRAC_W     = 6;
  localparam int PROD_W     = 2 * COLOR_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Hue steps inside one sixth of the color wheel.
  localparam logic [FRAC_W-1:0] FRAC_LAST = FRAC_W'(59);
  localparam logic [COLOR_W-1:0] COLOR_MAX = 8'd255;

  // Depth of the command queue between front and back.
  localparam int CMD_QUEUE_DEPTH = 2;

  // Operation codes.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SATURATION  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_LEVEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_ONE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_TWO     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_THREE   = 3'd4;

  // Configuration reset values.
  localparam logic [COLOR_W-1:0] SATURATION_RESET  = 8'd255;
  localparam logic [COLOR_W-1:0] VALUE_LEVEL_RESET = 8'd255;
  localparam logic [POS_W-1:0]   TAP_ONE_RESET     = 6'd10;
  localparam logic [POS_W-1:0]   TAP_TWO_RESET     = 6'd30;
  localparam logic [POS_W-1:0]   TAP_THREE_RESET   = 6'd50;

  // Strip select codes.
  localparam logic [SEL_W-1:0] STRIP_TRUNK       = 3'd0;
  localparam logic [SEL_W-1:0] STRIP_ONE_LEFT    = 3'd1;
  localparam logic [SEL_W-1:0] STRIP_ONE_RIGHT   = 3'd2;
  localparam logic [SEL_W-1:0] STRIP_TWO_LEFT    = 3'd3;
  localparam logic [SEL_W-1:0] STRIP_TWO_RIGHT   = 3'd4;
  localparam logic [SEL_W-1:0] STRIP_THREE_LEFT  = 3'd5;
  localparam logic [SEL_W-1:0] STRIP_THREE_RIGHT = 3'd6;
  localparam logic [SEL_W-1:0] STRIP_UNUSED      = 3'd7;

  // Which store a read goes to.
  typedef enum logic [2:0] {
    ST_TRUNK,
    ST_BRANCH_ONE,
    ST_BRANCH_TWO,
    ST_BRANCH_THREE,
    ST_NONE
  } store_e;

  // Sixths of the hue wheel.
  typedef enum logic [2:0] {
    HS_RED_YELLOW,
    HS_YELLOW_GREEN,
    HS_GREEN_CYAN,
    HS_CYAN_BLUE,
    HS_BLUE_MAGENTA,
    HS_MAGENTA_RED
  } hue_sector_e;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_TICK_DIV,
    BK_TICK_MIX,
    BK_TICK_WR,
    BK_READ_OUT
  } back_state_e;

  // A classified item as it travels through the queue.
  typedef struct packed {
    logic             is_tick;
    store_e           store;
    logic [POS_W-1:0] pos;
    logic             pos_ok;
  } cmd_t;

  // Push side of the command queue.
  typedef struct packed {
    logic push;
    cmd_t cmd;
  } q_wr_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [COLOR_W-1:0] saturation;
    logic [COLOR_W-1:0] value_level;
    logic [POS_W-1:0]   tap_one;
    logic [POS_W-1:0]   tap_two;
    logic [POS_W-1:0]   tap_three;
  } cfg_t;

  // Truncating divide by 255 for a product of two 8-bit values.
  function automatic logic [COLOR_W-1:0] div255(input logic [PROD_W-1:0] x);
    logic [PROD_W-1:0] sum;
    sum = x + (x >> COLOR_W) + PROD_W'(1);
    return sum[PROD_W-1:COLOR_W];
  endfunction

  // Fractional hue scaled to 0..250: frac * 255 / 60 equals frac * 17 / 4.
  function automatic logic [COLOR_W-1:0] frac_scale(input logic [FRAC_W-1:0] frac);
    logic [FRAC_W+3:0] x17;
    x17 = {frac, 4'b0000} + (FRAC_W + 4)'(frac);
    return x17[FRAC_W+3:2];
  endfunction

endpackage

`default_nettype wire

>>> rtl/rhlt_if.sv
// Valid/ready channel interfaces for the input items and the result items.
`default_nettype none

interface rhlt_in_if import rhlt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             operation;
  logic [SEL_W-1:0] strip_select;
  logic [POS_W-1:0] led_index;

  modport source (output valid, output operation, output strip_select, output led_index,
                  input ready);
  modport sink (input valid, input operation, input strip_select, input led_index,
                output ready);
endinterface

interface rhlt_out_if import rhlt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

>>> rtl/rainbow_hsv_led_tree_pattern.sv
// Top level of the rainbow LED tree pattern generator: configuration registers and wiring.
// A tick runs the sequencer through its divide, mix and write states and a read through
// its output state; a tick runs three tap reads through the single read port of the line
// memory. Both wait for a free result register; a 2-entry queue keeps the input open.
// Reset loads the configuration defaults, zero hue and an empty fill count, so every line
// reads black at once; no clearing pass is needed.
`default_nettype none

module rainbow_hsv_led_tree_pattern import rhlt_pkg::*; #(
  parameter int LED_COUNT = 60
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  rhlt_in_if.sink               in_i,
  rhlt_out_if.source            out_o
);

  cfg_t  cfg_q;
  q_wr_t q_wr;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;
  cmd_t  q_head;

  // Configuration registers; writes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.saturation  <= SATURATION_RESET;
      cfg_q.value_level <= VALUE_LEVEL_RESET;
      cfg_q.tap_one     <= TAP_ONE_RESET;
      cfg_q.tap_two     <= TAP_TWO_RESET;
      cfg_q.tap_three   <= TAP_THREE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SATURATION:  cfg_q.saturation  <= cfg_data_i;
        CFG_VALUE_LEVEL: cfg_q.value_level <= cfg_data_i;
        CFG_TAP_ONE:     cfg_q.tap_one     <= cfg_data_i[POS_W-1:0];
        CFG_TAP_TWO:     cfg_q.tap_two     <= cfg_data_i[POS_W-1:0];
        CFG_TAP_THREE:   cfg_q.tap_three   <= cfg_data_i[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end classifies transactions into commands.
  rhlt_front #(
    .LED_COUNT (LED_COUNT)
  ) u_front (
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_wr_o   (q_wr)
  );

  // Queue between the front and back ends.
  rhlt_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  // Back end executes commands and drives the result channel.
  rhlt_back #(
    .LED_COUNT (LED_COUNT)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_empty_i (q_empty),
    .q_head_i  (q_head),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire

>>> rtl/rhlt_front.sv
// Front end: accepts input items and classifies them into queue commands.
`default_nettype none

module rhlt_front import rhlt_pkg::*; #(
  parameter int LED_COUNT = 60
) (
  rhlt_in_if.sink in_i,
  input  logic    q_full_i,
  output q_wr_t   q_wr_o
);

  // Items are taken whenever the queue has room.
  assign in_i.ready = !q_full_i;

  // Decode the operation and the strip, and check the LED position.
  always_comb begin
    q_wr_o.push       = in_i.valid && !q_full_i;
    q_wr_o.cmd.is_tick = (in_i.operation == OP_TICK);
    q_wr_o.cmd.pos    = in_i.led_index;
    q_wr_o.cmd.pos_ok = (int'(in_i.led_index) < LED_COUNT);
    unique case (in_i.strip_select)
      STRIP_TRUNK:                         q_wr_o.cmd.store = ST_TRUNK;
      STRIP_ONE_LEFT, STRIP_ONE_RIGHT:     q_wr_o.cmd.store = ST_BRANCH_ONE;
      STRIP_TWO_LEFT, STRIP_TWO_RIGHT:     q_wr_o.cmd.store = ST_BRANCH_TWO;
      STRIP_THREE_LEFT, STRIP_THREE_RIGHT: q_wr_o.cmd.store = ST_BRANCH_THREE;
      STRIP_UNUSED:                        q_wr_o.cmd.store = ST_NONE;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/rhlt_cmd_queue.sv
// Short command queue that decouples the front end from the back end.
`default_nettype none

module rhlt_cmd_queue import rhlt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  q_wr_t wr_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output cmd_t  head_o
);

  localparam int DEPTH = CMD_QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = entry_q[rd_ptr_q];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_i.push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_i.push && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !wr_i.push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage carries no reset.
  always_ff @(posedge clk_i) begin
    if (wr_i.push) begin
      entry_q[wr_ptr_q] <= wr_i.cmd;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rhlt_back.sv
// Back end: HSV conversion, LED line memory, tap transfers and the result register.
`default_nettype none

module rhlt_back import rhlt_pkg::*; #(
  parameter int LED_COUNT = 60
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  q_empty_i,
  input  cmd_t  q_head_i,
  output logic  q_pop_o,
  rhlt_out_if.source out_o
);

  localparam int AW   = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int FW   = AW + 1;
  localparam int CW   = ((FW > POS_W) ? FW : POS_W) + 1;
  localparam int LAST = LED_COUNT - 1;

  back_state_e        state_q, state_d;
  logic [AW-1:0]      head_q;
  logic [AW-1:0]      head_new;
  logic [FW-1:0]      fill_q;
  logic [FRAC_W-1:0]  frac_q;
  hue_sector_e        sector_q;
  cmd_t               cmd_q;

  logic [PROD_W-1:0]  m1_q, m2_q, m3_q;
  logic [COLOR_W-1:0] a_q, b_q, p_q, q_q, t_q;
  logic [COLOR_W-1:0] f_val;
  logic [COLOR_W-1:0] v_val;
  logic [RGB_W-1:0]   tap1_q, tap2_q;

  logic [LINE_W-1:0]  line_mem [LED_COUNT];
  logic [LINE_W-1:0]  rdata_q;
  logic [AW-1:0]      rd_addr;
  logic               rd_en;
  logic               mem_we;

  logic [CW-1:0]      tap1_s, tap2_s, tap3_s;
  logic [RGB_W-1:0]   colour;
  logic [RGB_W-1:0]   br1, br2, br3;
  logic [RGB_W-1:0]   trunk_rd;
  logic [RGB_W-1:0]   read_colour;
  logic [RGB_W-1:0]   result;
  logic               out_free;
  logic               out_load;
  logic               tick_commit;
  logic               out_valid_q;
  logic [RGB_W-1:0]   out_rgb_q;

  // Clamp a tap to the last LED of the line.
  function automatic logic [CW-1:0] tap_sat(input logic [POS_W-1:0] tap);
    return (CW'(tap) >= CW'(LED_COUNT)) ? CW'(LAST) : CW'(tap);
  endfunction

  // Circular address of an LED position relative to a head.
  function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] base,
                                              input logic [CW-1:0] off);
    logic [CW-1:0] sum;
    sum = CW'(base) + off;
    if (sum >= CW'(LED_COUNT)) begin
      sum = sum - CW'(LED_COUNT);
    end
    return sum[AW-1:0];
  endfunction

  // Branch: new color at tap zero, old trunk data inside the fill, else black.
  function automatic logic [RGB_W-1:0] branch_in(input logic [CW-1:0]    ts,
                                                 input logic [RGB_W-1:0] fresh,
                                                 input logic [RGB_W-1:0] old,
                                                 input logic [FW-1:0]    fill);
    logic [RGB_W-1:0] res;
    if (ts == '0) begin
      res = fresh;
    end else if (ts <= CW'(fill)) begin
      res = old;
    end else begin
      res = '0;
    end
    return res;
  endfunction

  assign head_new = (head_q == '0) ? AW'(LAST) : head_q - 1'b1;
  assign tap1_s   = tap_sat(cfg_i.tap_one);
  assign tap2_s   = tap_sat(cfg_i.tap_two);
  assign tap3_s   = tap_sat(cfg_i.tap_three);
  assign f_val    = frac_scale(frac_q);
  assign v_val    = cfg_i.value_level;
  assign trunk_rd = rdata_q[LINE_W-1 -: RGB_W];
  assign out_free = !out_valid_q || out_o.ready;

  // Sequencer: a tick walks three tap reads through the memory port, a read one.
  always_comb begin
    state_d     = state_q;
    q_pop_o     = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = head_q;
    mem_we      = 1'b0;
    out_load    = 1'b0;
    tick_commit = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          rd_en   = 1'b1;
          if (q_head_i.is_tick) begin
            rd_addr = wrap_addr(head_new, tap1_s);
            state_d = BK_TICK_DIV;
          end else begin
            rd_addr = wrap_addr(head_q, q_head_i.pos_ok ? CW'(q_head_i.pos) : '0);
            state_d = BK_READ_OUT;
          end
        end
      end
      BK_TICK_DIV: begin
        rd_en   = 1'b1;
        rd_addr = wrap_addr(head_new, tap2_s);
        state_d = BK_TICK_MIX;
      end
      BK_TICK_MIX: begin
        rd_en   = 1'b1;
        rd_addr = wrap_addr(head_new, tap3_s);
        state_d = BK_TICK_WR;
      end
      BK_TICK_WR: begin
        if (out_free) begin
          mem_we      = 1'b1;
          out_load    = 1'b1;
          tick_commit = 1'b1;
          state_d     = BK_IDLE;
        end
      end
      BK_READ_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Pick the RGB order for the current sixth of the hue wheel.
  always_comb begin
    unique case (sector_q)
      HS_RED_YELLOW:   colour = {v_val, t_q, p_q};
      HS_YELLOW_GREEN: colour = {q_q, v_val, p_q};
      HS_GREEN_CYAN:   colour = {p_q, v_val, t_q};
      HS_CYAN_BLUE:    colour = {p_q, q_q, v_val};
      HS_BLUE_MAGENTA: colour = {t_q, p_q, v_val};
      default:         colour = {v_val, p_q, q_q};
    endcase
  end

  assign br1 = branch_in(tap1_s, colour, tap1_q, fill_q);
  assign br2 = branch_in(tap2_s, colour, tap2_q, fill_q);
  assign br3 = branch_in(tap3_s, colour, trunk_rd, fill_q);

  // Read result: only written positions of a real strip return data.
  always_comb begin
    read_colour = '0;
    if (cmd_q.pos_ok && (CW'(cmd_q.pos) < CW'(fill_q))) begin
      unique case (cmd_q.store)
        ST_TRUNK:        read_colour = rdata_q[LINE_W-1 -: RGB_W];
        ST_BRANCH_ONE:   read_colour = rdata_q[LINE_W-RGB_W-1 -: RGB_W];
        ST_BRANCH_TWO:   read_colour = rdata_q[2*RGB_W-1 -: RGB_W];
        ST_BRANCH_THREE: read_colour = rdata_q[RGB_W-1:0];
        default:         read_colour = '0;
      endcase
    end
  end

  assign result = (state_q == BK_TICK_WR) ? colour : read_colour;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      head_q      <= '0;
      fill_q      <= '0;
      frac_q      <= '0;
      sector_q    <= HS_RED_YELLOW;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (tick_commit) begin
        head_q <= head_new;
        if (fill_q != FW'(LED_COUNT)) begin
          fill_q <= fill_q + 1'b1;
        end
        if (frac_q == FRAC_LAST) begin
          frac_q <= '0;
          unique case (sector_q)
            HS_RED_YELLOW:   sector_q <= HS_YELLOW_GREEN;
            HS_YELLOW_GREEN: sector_q <= HS_GREEN_CYAN;
            HS_GREEN_CYAN:   sector_q <= HS_CYAN_BLUE;
            HS_CYAN_BLUE:    sector_q <= HS_BLUE_MAGENTA;
            HS_BLUE_MAGENTA: sector_q <= HS_MAGENTA_RED;
            default:         sector_q <= HS_RED_YELLOW;
          endcase
        end else begin
          frac_q <= frac_q + 1'b1;
        end
      end
    end
  end

  // HSV datapath: multiply, divide by 255, multiply again, one step per state.
  always_ff @(posedge clk_i) begin
    if (state_q == BK_IDLE) begin
      m1_q  <= PROD_W'(f_val) * PROD_W'(cfg_i.saturation);
      m2_q  <= PROD_W'(COLOR_MAX - f_val) * PROD_W'(cfg_i.saturation);
      m3_q  <= PROD_W'(COLOR_MAX - cfg_i.saturation) * PROD_W'(v_val);
      cmd_q <= q_head_i;
    end
    if (state_q == BK_TICK_DIV) begin
      a_q    <= COLOR_MAX - div255(m1_q);
      b_q    <= COLOR_MAX - div255(m2_q);
      p_q    <= div255(m3_q);
      tap1_q <= trunk_rd;
    end
    if (state_q == BK_TICK_MIX) begin
      q_q    <= div255(PROD_W'(a_q) * PROD_W'(v_val));
      t_q    <= div255(PROD_W'(b_q) * PROD_W'(v_val));
      tap2_q <= trunk_rd;
    end
    if (out_load) begin
      out_rgb_q <= result;
    end
  end

  // Line memory: trunk and the three branch lines share one word per LED.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[head_new] <= {colour, br1, br2, br3};
    end
    if (rd_en) begin
      rdata_q <= line_mem[rd_addr];
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.red   = out_rgb_q[RGB_W-1 -: COLOR_W];
  assign out_o.green = out_rgb_q[2*COLOR_W-1 -: COLOR_W];
  assign out_o.blue  = out_rgb_q[COLOR_W-1:0];

  // The fill count never passes the line length.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= FW'(LED_COUNT))
    else $error("fill count beyond line length");

  // The head always addresses an existing LED.
  assert property (@(posedge clk_i) disable iff (!rst_ni) FW'(head_q) < FW'(LED_COUNT))
    else $error("head pointer out of range");

  // A committed tick grows the fill count until the line is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_commit |=> (fill_q == FW'($past(fill_q) + 1'b1)) || (fill_q == FW'(LED_COUNT)))
    else $error("fill count did not follow a tick");

  // A committed tick moves the head back by one place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_commit |=> head_q == $past(head_new))
    else $error("head pointer did not step on a tick");

endmodule

`default_nettype wire
